/* hdl/mks_pkg.sv */
// Package for the multi-key stream substitution block.
// Holds beat structs, function codes and size constants; no dependencies.
`default_nettype none
package mks_pkg;
  localparam int NumEntries  = 8;
  localparam int MaxKeyLen   = 8;
  localparam int MaxValueLen = 8;

  typedef enum logic [1:0] {
    FUNC_LOAD_KEY = 2'd0,
    FUNC_LOAD_VAL = 2'd1,
    FUNC_TEXT     = 2'd2,
    FUNC_END      = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] entry;
    logic [2:0] position;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } out_beat_t;
endpackage
`default_nettype wire

/* hdl/multi_key_stream_substitution.sv */
// Streaming multi-key find and replace. Key and value strings are loaded one
// byte per beat; text beats fill a lookahead window as long as the maximum
// key length. Once the window is full, a row of compare cells (one per window
// byte) decides combinationally which entry matches at the front, the lowest
// entry winning. Each emitted byte (a value byte of the winning key, or the
// front byte itself) is first read from the value store and then loaded into
// the output register. After a text beat that fills the window the input is
// held off until that emission is done, after an end-of-text beat until the
// whole flush is done; every other beat is accepted without holding it, and
// output stalls lengthen either hold. During a flush the newest byte is held
// back one step so the last flag can ride on it.
// Depends on mks_pkg and mks_cell.
`default_nettype none
module multi_key_stream_substitution #(
  parameter int NUM_ENTRIES   = mks_pkg::NumEntries,
  parameter int MAX_KEY_LEN   = mks_pkg::MaxKeyLen,
  parameter int MAX_VALUE_LEN = mks_pkg::MaxValueLen
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mks_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mks_pkg::out_beat_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata
);
  localparam int EW = $clog2(NUM_ENTRIES) > 0 ? $clog2(NUM_ENTRIES) : 1;
  localparam int KW = $clog2(MAX_KEY_LEN + 1);
  localparam int VW = $clog2(MAX_VALUE_LEN + 1);
  localparam int KI = $clog2(MAX_KEY_LEN) > 0 ? $clog2(MAX_KEY_LEN) : 1;
  localparam int VI = $clog2(MAX_VALUE_LEN) > 0 ? $clog2(MAX_VALUE_LEN) : 1;
  localparam int AW = $clog2(NUM_ENTRIES * MAX_VALUE_LEN) > 0 ?
                      $clog2(NUM_ENTRIES * MAX_VALUE_LEN) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0]  active_r;
  logic [KW-1:0] klen_r [NUM_ENTRIES];
  logic [VW-1:0] vlen_r [NUM_ENTRIES];
  logic [7:0]  val_mem [NUM_ENTRIES*MAX_VALUE_LEN];
  logic [7:0]  win_r [MAX_KEY_LEN];
  logic [KW-1:0] fill_r;
  logic        flush_r, from_val_r;
  logic [EW-1:0] hit_r;
  logic [VW-1:0] vcnt_r;
  logic [KW-1:0] drop_r;
  logic [7:0]  vrd_r;
  mks_pkg::out_beat_t ob_r;
  logic        ob_v_r;
  logic [7:0]  pend_r;
  logic        pend_v_r;

  // Entry and position decode for load beats.
  logic ent_ok, kpos_ok, vpos_ok, acc;
  assign acc    = in_valid & in_ready;
  assign ent_ok  = 32'(in_data.entry) < NUM_ENTRIES;
  assign kpos_ok = 32'(in_data.position) < MAX_KEY_LEN;
  assign vpos_ok = 32'(in_data.position) < MAX_VALUE_LEN;

  // Entries searched this pass.
  logic [NUM_ENTRIES-1:0] in_use;
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      in_use[e] = (32'(active_r) > e) && (klen_r[e] != '0) && (klen_r[e] <= fill_r);
    end
  end

  // The chain of compare cells.
  logic [NUM_ENTRIES-1:0] chain [MAX_KEY_LEN+1];
  assign chain[0] = in_use;
  for (genvar c = 0; c < MAX_KEY_LEN; c++) begin : g_cell
    logic [NUM_ENTRIES-1:0] cov;
    always_comb begin
      for (int e = 0; e < NUM_ENTRIES; e++) cov[e] = 32'(klen_r[e]) > c;
    end
    mks_cell #(.NUM_ENTRIES(NUM_ENTRIES)) u_cell (
      .clk      (clk),
      .key_we   (acc && in_data.func == mks_pkg::FUNC_LOAD_KEY && ent_ok && kpos_ok
                 && 32'(in_data.position) == c),
      .key_entry(EW'(in_data.entry)),
      .key_byte (in_data.data_byte),
      .win_byte (win_r[c]),
      .key_cov  (cov),
      .match_in (chain[c]),
      .match_out(chain[c+1])
    );
  end

  // Lowest matching entry.
  logic          any_hit;
  logic [EW-1:0] hit_idx;
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
      if (chain[MAX_KEY_LEN][e]) begin
        any_hit = 1'b1;
        hit_idx = EW'(e);
      end
    end
  end

  logic out_free;
  assign out_free = ~ob_v_r | out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Value addresses for the load write and the byte being emitted.
  logic [VI-1:0] vaddr_pos;
  logic [AW-1:0] vwr_addr, vrd_addr;
  assign vaddr_pos = VI'(vcnt_r);
  assign vwr_addr  = AW'(32'(in_data.entry) * MAX_VALUE_LEN + 32'(in_data.position));
  assign vrd_addr  = AW'(32'(hit_r) * MAX_VALUE_LEN + 32'(vaddr_pos));

  always_ff @(posedge clk) begin
    if (acc && in_data.func == mks_pkg::FUNC_LOAD_VAL && ent_ok && vpos_ok) begin
      val_mem[vwr_addr] <= in_data.data_byte;
    end
    vrd_r <= val_mem[vrd_addr];
  end

  // Sequencer: check the front, then emit its bytes one at a time.
  logic vread_ok_r;
  logic emit_now, emit_last_byte;
  always_comb begin
    state_nxt = state_r;
    emit_now = 1'b0;
    emit_last_byte = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_data.func == mks_pkg::FUNC_TEXT) begin
          state_nxt = (32'(fill_r) + 1 >= MAX_KEY_LEN) ? ST_CHECK : ST_IDLE;
        end else if (acc && in_data.func == mks_pkg::FUNC_END) begin
          state_nxt = (fill_r != '0) ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free && !vread_ok_r) begin
          if (from_val_r) begin
            emit_now = vcnt_r < vlen_r[hit_r];
            emit_last_byte = (vcnt_r + 1'b1 >= vlen_r[hit_r]);
          end else begin
            emit_now = 1'b1;
            emit_last_byte = 1'b1;
          end
          if (emit_last_byte) begin
            if (flush_r && fill_r > drop_r) state_nxt = ST_CHECK;
            else if (flush_r) state_nxt = ST_DONE;
            else state_nxt = ST_IDLE;
          end
        end
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register load: text bytes go straight out, flush bytes go out one
  // step late, and the end beat carries the held byte or an empty marker.
  logic               emit_step;
  logic [7:0]         emit_byte;
  logic               ob_load;
  mks_pkg::out_beat_t ob_nxt;
  assign emit_step = (state_r == ST_EMIT) && out_free && !vread_ok_r;
  assign emit_byte = from_val_r ? vrd_r : win_r[0];
  always_comb begin
    ob_load = 1'b0;
    ob_nxt  = '0;
    if (emit_step && emit_now && !flush_r) begin
      ob_load = 1'b1;
      ob_nxt  = '{out_byte: emit_byte, byte_valid: 1'b1, last: 1'b0};
    end else if (emit_step && emit_now && pend_v_r) begin
      ob_load = 1'b1;
      ob_nxt  = '{out_byte: pend_r, byte_valid: 1'b1, last: 1'b0};
    end else if (state_r == ST_DONE && out_free) begin
      ob_load = 1'b1;
      ob_nxt  = '{out_byte: pend_v_r ? pend_r : 8'd0, byte_valid: pend_v_r, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      active_r <= 4'd1;
      fill_r <= '0;
      ob_v_r <= 1'b0;
      flush_r <= 1'b0;
      pend_v_r <= 1'b0;
      vread_ok_r <= 1'b0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        klen_r[e] <= '0;
        vlen_r[e] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) active_r <= cfg_wdata;
      if (ob_load) begin
        ob_v_r <= 1'b1;
        ob_r <= ob_nxt;
      end else if (out_ready) begin
        ob_v_r <= 1'b0;
      end
      vread_ok_r <= (state_r == ST_CHECK) || emit_step;
      if (acc && in_data.final_byte && ent_ok) begin
        if (in_data.func == mks_pkg::FUNC_LOAD_KEY && kpos_ok)
          klen_r[EW'(in_data.entry)] <= KW'(in_data.position) + 1'b1;
        if (in_data.func == mks_pkg::FUNC_LOAD_VAL && vpos_ok)
          vlen_r[EW'(in_data.entry)] <= VW'(in_data.position) + 1'b1;
      end
      if (acc && in_data.func == mks_pkg::FUNC_TEXT) begin
        if (32'(fill_r) < MAX_KEY_LEN) begin
          win_r[fill_r[KI-1:0]] <= in_data.data_byte;
          fill_r <= fill_r + 1'b1;
        end
        flush_r <= 1'b0;
      end
      if (acc && in_data.func == mks_pkg::FUNC_END) begin
        flush_r <= 1'b1;
      end
      // Latch the decision and start the value read.
      if (state_r == ST_CHECK) begin
        hit_r <= hit_idx;
        from_val_r <= any_hit;
        vcnt_r <= '0;
        drop_r <= any_hit ? klen_r[hit_idx] : KW'(1);
      end
      if (emit_step) begin
        // During a flush the newest byte waits for the next one or the end.
        if (emit_now && flush_r) begin
          pend_r <= emit_byte;
          pend_v_r <= 1'b1;
        end
        vcnt_r <= vcnt_r + 1'b1;
        if (emit_last_byte) begin
          for (int i = 0; i < MAX_KEY_LEN; i++) begin
            if (32'(i) + 32'(drop_r) < MAX_KEY_LEN)
              win_r[i] <= win_r[KI'(32'(i) + 32'(drop_r))];
          end
          fill_r <= (fill_r > drop_r) ? fill_r - drop_r : '0;
        end
      end
      if (state_r == ST_DONE && out_free) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = ob_v_r;
  assign out_data  = ob_r;
endmodule
`default_nettype wire

/* hdl/mks_cell.sv */
// One compare cell of the key chain: holds one key byte per entry, compares
// them with one window byte, and passes the running match flags on to its neighbor.
// Depends on mks_pkg.
`default_nettype none
module mks_cell #(
  parameter int NUM_ENTRIES = mks_pkg::NumEntries
) (
  input  wire logic                   clk,
  input  wire logic                   key_we,
  input  wire logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] key_entry,
  input  wire logic [7:0]             key_byte,
  input  wire logic [7:0]             win_byte,
  input  wire logic [NUM_ENTRIES-1:0] key_cov,
  input  wire logic [NUM_ENTRIES-1:0] match_in,
  output logic      [NUM_ENTRIES-1:0] match_out
);
  logic [7:0] key_r [NUM_ENTRIES];

  // Key byte storage, written by load beats.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_r[key_entry] <= key_byte;
    end
  end

  // A byte outside an entry's key length always agrees.
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      match_out[e] = match_in[e] & (~key_cov[e] | (key_r[e] == win_byte));
    end
  end
endmodule
`default_nettype wire

/* tb/tb_multi_key_stream_substitution.sv */
// Testbench for multi_key_stream_substitution: directed table plus random traffic,
// checked beat by beat against an in-bench substitution predictor.
// Depends on mks_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_multi_key_stream_substitution;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  mks_pkg::in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  mks_pkg::out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  multi_key_stream_substitution u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: table, window and active count.
  logic [7:0] key_mem [64];
  logic [7:0] val_mem [64];
  bit         key_wr [64];
  bit         val_wr [64];
  int         key_len [8];
  int         val_len [8];
  logic [7:0] window [8];
  int         fill;
  int         active;

  mks_pkg::out_beat_t rewrite_q[$];
  int         err_count;
  bit         no_idle;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void push_byte(logic [7:0] b, logic v);
    mks_pkg::out_beat_t o;
    o.out_byte = b;
    o.byte_valid = v;
    o.last = 1'b0;
    rewrite_q.push_back(o);
  endfunction

  // Match the window front, emit a replacement or the front byte, then shift.
  function automatic void rewrite_front();
    int hit;
    int lim;
    int drop;
    bit ok;
    hit = -1;
    lim = (active > mks_pkg::NumEntries) ? mks_pkg::NumEntries : active;
    for (int e = 0; e < lim && hit < 0; e++) begin
      if (key_len[e] != 0 && key_len[e] <= fill) begin
        ok = 1'b1;
        for (int j = 0; j < key_len[e]; j++)
          if (key_mem[e * mks_pkg::MaxKeyLen + j] != window[j]) ok = 1'b0;
        if (ok) hit = e;
      end
    end
    if (hit >= 0) begin
      for (int j = 0; j < val_len[hit]; j++)
        push_byte(val_mem[hit * mks_pkg::MaxValueLen + j], 1'b1);
      drop = key_len[hit];
    end else begin
      push_byte(window[0], 1'b1);
      drop = 1;
    end
    if (drop >= fill) begin
      fill = 0;
    end else begin
      for (int j = 0; j < fill - drop; j++) window[j] = window[j + drop];
      fill = fill - drop;
    end
  endfunction

  // Expected beats for one accepted input beat.
  function automatic void predict_rewrite(mks_pkg::in_beat_t b);
    int q_start;
    mks_pkg::out_beat_t t;
    q_start = rewrite_q.size();
    case (mks_pkg::func_t'(b.func))
      mks_pkg::FUNC_LOAD_KEY: begin
        key_mem[b.entry * mks_pkg::MaxKeyLen + b.position] = b.data_byte;
        key_wr[b.entry * mks_pkg::MaxKeyLen + b.position] = 1'b1;
        if (b.final_byte) key_len[b.entry] = int'(b.position) + 1;
      end
      mks_pkg::FUNC_LOAD_VAL: begin
        val_mem[b.entry * mks_pkg::MaxValueLen + b.position] = b.data_byte;
        val_wr[b.entry * mks_pkg::MaxValueLen + b.position] = 1'b1;
        if (b.final_byte) val_len[b.entry] = int'(b.position) + 1;
      end
      mks_pkg::FUNC_TEXT: begin
        if (fill < mks_pkg::MaxKeyLen) begin
          window[fill] = b.data_byte;
          fill++;
        end
        if (fill >= mks_pkg::MaxKeyLen) rewrite_front();
      end
      default: begin
        while (fill > 0) rewrite_front();
        if (rewrite_q.size() == q_start) push_byte(8'h00, 1'b0);
        t = rewrite_q.pop_back();
        t.last = 1'b1;
        rewrite_q.push_back(t);
      end
    endcase
  endfunction

  // Result side: random stalls and in-order compare.
  always @(posedge clk) begin
    mks_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rewrite_q.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_data), 0);
      end else begin
        want = rewrite_q.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
        if (out_data.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", int'(out_data.byte_valid), int'(want.byte_valid));
        if (out_data.last !== want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
      end
    end
    out_ready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  // Drive one beat and hold it until accepted; typed rows replace the prediction.
  task automatic send_beat(mks_pkg::in_beat_t b, bit typed = 1'b0,
                           mks_pkg::out_beat_t typed_exp = '0);
    int q_start;
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 50);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    q_start = rewrite_q.size();
    predict_rewrite(b);
    if (typed) begin
      while (rewrite_q.size() > q_start) void'(rewrite_q.pop_back());
      rewrite_q.push_back(typed_exp);
    end
  endtask

  function automatic mks_pkg::in_beat_t mk(mks_pkg::func_t f, int e, int p, int d, bit fin);
    mks_pkg::in_beat_t b;
    b.func = f;
    b.entry = 3'(e);
    b.position = 3'(p);
    b.data_byte = 8'(d);
    b.final_byte = fin;
    return b;
  endfunction

  // Write the active count once the block has drained.
  task automatic set_active(int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 4'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    active = v;
  endtask

  // Mostly whole key/value loads and text over a small alphabet, plus noise.
  task automatic run_phase(int n);
    int cnt;
    int r;
    int e;
    int len;
    int p;
    bit is_val;
    bit fin;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        e = $urandom_range(0, 7);
        is_val = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_beat(mk(is_val ? mks_pkg::FUNC_LOAD_VAL : mks_pkg::FUNC_LOAD_KEY, e, k,
                       8'h61 + $urandom_range(0, 3), k == len - 1));
        cnt += len;
      end else if (r < 17) begin
        // Stray load: only mark a length whose bytes are all written.
        e = $urandom_range(0, 7);
        p = $urandom_range(0, 7);
        is_val = 1'($urandom_range(0, 1));
        fin = 1'($urandom_range(0, 1));
        for (int k = 0; k < p; k++)
          if (!(is_val ? val_wr[e * 8 + k] : key_wr[e * 8 + k])) fin = 1'b0;
        send_beat(mk(is_val ? mks_pkg::FUNC_LOAD_VAL : mks_pkg::FUNC_LOAD_KEY, e, p,
                     $urandom_range(0, 255), fin));
        cnt++;
      end else if (r < 22) begin
        send_beat(mk(mks_pkg::FUNC_END, $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 255), 1'($urandom_range(0, 1))));
        cnt++;
      end else begin
        send_beat(mk(mks_pkg::FUNC_TEXT, $urandom_range(0, 7), $urandom_range(0, 7),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : 8'h61 + $urandom_range(0, 3),
                     1'($urandom_range(0, 1))));
        cnt++;
      end
    end
  endtask

  typedef struct {
    mks_pkg::in_beat_t  b;
    bit                 typed;
    mks_pkg::out_beat_t exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    dir_row_t row;
    int phase_vals[6];
    fill = 0;
    active = 1;
    err_count = 0;
    no_idle = 1'b0;
    for (int i = 0; i < 8; i++) begin
      key_len[i] = 0;
      val_len[i] = 0;
    end
    for (int i = 0; i < 64; i++) begin
      key_wr[i] = 1'b0;
      val_wr[i] = 1'b0;
    end

    // Directed table: empty end after reset is known outright.
    row = '{mk(mks_pkg::FUNC_END, 0, 0, 0, 0), 1'b1, '{8'h00, 1'b0, 1'b1}};
    dir_rows.push_back(row);
    row.typed = 1'b0;
    row.b = mk(mks_pkg::FUNC_LOAD_KEY, 0, 0, 8'h61, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_LOAD_KEY, 0, 1, 8'h62, 1); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_LOAD_VAL, 0, 0, 8'h58, 1); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_LOAD_KEY, 1, 0, 8'h00, 1); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_LOAD_KEY, 2, 0, 8'hFF, 1); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_LOAD_VAL, 1, 0, 8'hFF, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_LOAD_VAL, 1, 1, 8'h00, 1); dir_rows.push_back(row);
    foreach (phase_vals[i]) phase_vals[i] = 0;
    row.b = mk(mks_pkg::FUNC_TEXT, 7, 7, 8'h61, 1); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h62, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h00, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'hFF, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h61, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h62, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h61, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h62, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h63, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_TEXT, 0, 0, 8'h61, 0); dir_rows.push_back(row);
    row.b = mk(mks_pkg::FUNC_END, 7, 7, 8'hFF, 1); dir_rows.push_back(row);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].exp);

    // Settings sweep: all entries, none, above range, mid values, reset value.
    phase_vals = '{8, 0, 15, 3, 5, 1};
    foreach (phase_vals[i]) begin
      set_active(phase_vals[i]);
      no_idle = (i == 2);
      run_phase(72);
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
